### sv/msc_pkg.sv
// ----------------------------------------------------------------------------
// msc_pkg
// Shared types and constants of the MIPS subset core: opcodes, status codes,
// architectural state and the per-beat result record.
// ----------------------------------------------------------------------------
package msc_pkg;

   localparam logic [31:0] RESET_PC_DEFAULT = 32'hBFC0_0000;
   localparam logic [31:0] REG_RESET_VALUE  = 32'hDEAD_BEEF;
   localparam int unsigned SR_ISOLATE_BIT   = 16;
   localparam logic [31:0] PC_REGION_MASK   = 32'hF000_0000;

   localparam logic [5:0] OPC_SPECIAL = 6'b000000;
   localparam logic [5:0] OPC_J       = 6'b000010;
   localparam logic [5:0] OPC_BNE     = 6'b000101;
   localparam logic [5:0] OPC_ADDI    = 6'b001000;
   localparam logic [5:0] OPC_ADDIU   = 6'b001001;
   localparam logic [5:0] OPC_ORI     = 6'b001101;
   localparam logic [5:0] OPC_LUI     = 6'b001111;
   localparam logic [5:0] OPC_COP0    = 6'b010000;
   localparam logic [5:0] OPC_LW      = 6'b100011;
   localparam logic [5:0] OPC_SW      = 6'b101011;

   localparam logic [5:0] FN_SLL = 6'b000000;
   localparam logic [5:0] FN_OR  = 6'b100101;

   localparam logic [4:0] COP0_RS_MTC0 = 5'd4;
   localparam logic [4:0] COP0_REG_SR  = 5'd12;

   localparam logic KIND_FETCH = 1'b0;
   localparam logic KIND_LOAD  = 1'b1;

   typedef enum logic [1:0] {
      MEM_NONE  = 2'd0,
      MEM_STORE = 2'd1,
      MEM_LOAD  = 2'd2
   } mem_op_type;

   typedef enum logic [2:0] {
      ST_OK         = 3'd0,
      ST_BAD_OPCODE = 3'd1,
      ST_BAD_COP0   = 3'd2,
      ST_OVERFLOW   = 3'd3,
      ST_HALTED     = 3'd4,
      ST_UNEXPECTED = 3'd5
   } status_type;

   typedef struct packed {
      logic [31:0] pc;
      logic [31:0] prefetch;
      logic [31:0] sr;
      logic        load_pending;
      logic [4:0]  load_target;
      logic        halted;
   } core_state_type;

   typedef struct packed {
      logic        en;
      logic [4:0]  addr;
      logic [31:0] data;
   } writeback_type;

   typedef struct packed {
      logic [31:0] fetch_address;
      mem_op_type  mem_op;
      logic [31:0] mem_address;
      logic [31:0] store_data;
      status_type  status;
   } result_type;

endpackage

### sv/msc_execute.sv
// ----------------------------------------------------------------------------
// msc_execute
// Single-beat execution logic: takes one beat, the architectural state and
// the two register operands of the prefetched instruction, and yields the
// next state, the register write-back and the result record.
// ----------------------------------------------------------------------------
module msc_execute (
   input  logic                    kind,
   input  logic [31:0]             word,
   input  msc_pkg::core_state_type state,
   input  logic [31:0]             rs_val,
   input  logic [31:0]             rt_val,
   output msc_pkg::core_state_type state_nxt,
   output msc_pkg::writeback_type  wb,
   output msc_pkg::result_type     res
);

   logic [31:0]         ins;
   logic [5:0]          opc;
   logic [4:0]          rs;
   logic [4:0]          rt;
   logic [4:0]          rd;
   logic [4:0]          sh;
   logic [5:0]          fn;
   logic [31:0]         imm;
   logic [31:0]         simm;
   logic [31:0]         pc4;
   logic [31:0]         sum;
   logic [31:0]         ea;
   logic                isolated;
   logic                ovf;
   msc_pkg::status_type st;

   assign ins      = state.prefetch;
   assign opc      = ins[31:26];
   assign rs       = ins[25:21];
   assign rt       = ins[20:16];
   assign rd       = ins[15:11];
   assign sh       = ins[10:6];
   assign fn       = ins[5:0];
   assign imm      = {16'h0000, ins[15:0]};
   assign simm     = {{16{ins[15]}}, ins[15:0]};
   assign pc4      = state.pc + 32'd4;
   assign sum      = rs_val + simm;
   assign ea       = sum;
   assign isolated = state.sr[msc_pkg::SR_ISOLATE_BIT];
   assign ovf      = (rs_val[31] == simm[31]) && (sum[31] != rs_val[31]);

   always_comb begin
      state_nxt           = state;
      wb                  = '0;
      st                  = msc_pkg::ST_OK;
      res.mem_op          = msc_pkg::MEM_NONE;
      res.mem_address     = '0;
      res.store_data      = '0;
      if (state.halted) begin
         st = msc_pkg::ST_HALTED;
      end else if (kind == msc_pkg::KIND_LOAD) begin
         if (state.load_pending) begin
            wb.en                  = 1'b1;
            wb.addr                = state.load_target;
            wb.data                = word;
            state_nxt.load_pending = 1'b0;
         end else begin
            st = msc_pkg::ST_UNEXPECTED;
         end
      end else if (state.load_pending) begin
         st = msc_pkg::ST_UNEXPECTED;
      end else begin
         state_nxt.prefetch = word;
         state_nxt.pc       = pc4;
         case (opc)
            msc_pkg::OPC_LUI: begin
               wb = '{en: 1'b1, addr: rt, data: {ins[15:0], 16'h0000}};
            end
            msc_pkg::OPC_ORI: begin
               wb = '{en: 1'b1, addr: rt, data: rs_val | imm};
            end
            msc_pkg::OPC_ADDIU: begin
               wb = '{en: 1'b1, addr: rt, data: sum};
            end
            msc_pkg::OPC_ADDI: begin
               if (ovf) begin
                  st = msc_pkg::ST_OVERFLOW;
               end else begin
                  wb = '{en: 1'b1, addr: rt, data: sum};
               end
            end
            msc_pkg::OPC_SPECIAL: begin
               case (fn)
                  msc_pkg::FN_SLL: wb = '{en: 1'b1, addr: rd, data: rt_val << sh};
                  msc_pkg::FN_OR:  wb = '{en: 1'b1, addr: rd, data: rs_val | rt_val};
                  default:         st = msc_pkg::ST_BAD_OPCODE;
               endcase
            end
            msc_pkg::OPC_J: begin
               state_nxt.pc = (pc4 & msc_pkg::PC_REGION_MASK) | {4'h0, ins[25:0], 2'b00};
            end
            msc_pkg::OPC_BNE: begin
               if (rs_val != rt_val) begin
                  state_nxt.pc = state.pc + {simm[29:0], 2'b00};
               end
            end
            msc_pkg::OPC_COP0: begin
               if (rs != msc_pkg::COP0_RS_MTC0) begin
                  st = msc_pkg::ST_BAD_OPCODE;
               end else if (rd != msc_pkg::COP0_REG_SR) begin
                  st = msc_pkg::ST_BAD_COP0;
               end else begin
                  state_nxt.sr = rt_val;
               end
            end
            msc_pkg::OPC_SW: begin
               if (!isolated) begin
                  res.mem_op      = msc_pkg::MEM_STORE;
                  res.mem_address = ea;
                  res.store_data  = rt_val;
               end
            end
            msc_pkg::OPC_LW: begin
               if (!isolated) begin
                  res.mem_op             = msc_pkg::MEM_LOAD;
                  res.mem_address        = ea;
                  state_nxt.load_pending = 1'b1;
                  state_nxt.load_target  = rt;
               end
            end
            default: begin
               st = msc_pkg::ST_BAD_OPCODE;
            end
         endcase
         if (st != msc_pkg::ST_OK) begin
            state_nxt.halted = 1'b1;
         end
      end
      if (wb.addr == 5'd0) begin
         wb.en = 1'b0;
      end
      res.fetch_address = state_nxt.pc;
      res.status        = st;
   end

endmodule

### sv/mips_subset_cpu_core.sv
// ----------------------------------------------------------------------------
// mips_subset_cpu_core
// MIPS R3000 subset core with a one-slot prefetch. Each fetch beat executes
// the previously fetched word; load-return beats complete a pending LW.
//
//   channel  dir  ports                          contents
//   req      in   req_tvalid/tready/tdata/tuser  tdata: word; tuser: kind
//   rsp      out  rsp_tvalid/tready/tdata        fetch, mem op/addr/data, status
//   csr      in   csr_we/csr_wdata               PC value (loads the PC directly)
//
// One beat per cycle sustained while rsp is ready; each beat passes through
// the input register and then the result register.
// Operands come from a registered-read register file, addressed from the
// next state's prefetched word, with same-cycle write bypass.
// A stalled rsp holds the result register and back-pressures req after one
// beat. Reset is synchronous; registers read 0xDEADBEEF until written, r0 reads 0.
// ----------------------------------------------------------------------------
module mips_subset_cpu_core (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [31:0]   req_tdata,   // [31:0] word
   input  logic          req_tuser,   // [0] kind
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [103:0]  rsp_tdata,   // [31:0] fetch_address, [33:32] mem_op,
                                      // [65:34] mem_address, [97:66] store_data,
                                      // [100:98] status, [103:101] zero
   input  logic          csr_we,
   input  logic [31:0]   csr_wdata
);

   logic                    in_vld_ff;
   logic                    in_kind_ff;
   logic [31:0]             in_word_ff;
   logic                    out_vld_ff;
   msc_pkg::result_type     out_res_ff;
   msc_pkg::core_state_type state_ff;
   msc_pkg::core_state_type state_in;
   msc_pkg::core_state_type exec_state;
   msc_pkg::writeback_type  wb;
   msc_pkg::result_type     exec_res;
   logic                    fire;
   logic [31:0]             regs_mem [32];
   logic [31:0]             regs_vld_ff;
   logic [31:0]             rs_val_ff;
   logic [31:0]             rt_val_ff;
   logic [4:0]              rs_addr;
   logic [4:0]              rt_addr;

   assign fire       = in_vld_ff && (!out_vld_ff || rsp_tready);
   assign req_tready = !in_vld_ff || fire;
   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {3'b000, out_res_ff.status, out_res_ff.store_data,
                        out_res_ff.mem_address, out_res_ff.mem_op,
                        out_res_ff.fetch_address};

   msc_execute u_execute (
      .kind      (in_kind_ff),
      .word      (in_word_ff),
      .state     (state_ff),
      .rs_val    (rs_val_ff),
      .rt_val    (rt_val_ff),
      .state_nxt (exec_state),
      .wb        (wb),
      .res       (exec_res)
   );

   always_comb begin
      state_in = fire ? exec_state : state_ff;
      if (csr_we) begin
         state_in.pc = csr_wdata;
      end
   end

   assign rs_addr = state_in.prefetch[25:21];
   assign rt_addr = state_in.prefetch[20:16];

   // input and result valid flags, and the architectural state register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
         state_ff   <= '{pc: msc_pkg::RESET_PC_DEFAULT, default: '0};
      end else begin
         state_ff <= state_in;
         if (req_tready) begin
            in_vld_ff <= req_tvalid;
         end
         if (fire) begin
            out_vld_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_vld_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_kind_ff <= req_tuser;
         in_word_ff <= req_tdata;
      end
      if (fire) begin
         out_res_ff <= exec_res;
      end
   end

   // register file: one write, two registered reads with bypass
   always_ff @(posedge clock) begin
      if (reset) begin
         regs_vld_ff <= '0;
      end else if (fire && wb.en) begin
         regs_vld_ff[wb.addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && wb.en) begin
         regs_mem[wb.addr] <= wb.data;
      end
      if (rs_addr == 5'd0) begin
         rs_val_ff <= '0;
      end else if (fire && wb.en && wb.addr == rs_addr) begin
         rs_val_ff <= wb.data;
      end else if (!regs_vld_ff[rs_addr] || reset) begin
         rs_val_ff <= msc_pkg::REG_RESET_VALUE;
      end else begin
         rs_val_ff <= regs_mem[rs_addr];
      end
      if (rt_addr == 5'd0) begin
         rt_val_ff <= '0;
      end else if (fire && wb.en && wb.addr == rt_addr) begin
         rt_val_ff <= wb.data;
      end else if (!regs_vld_ff[rt_addr] || reset) begin
         rt_val_ff <= msc_pkg::REG_RESET_VALUE;
      end else begin
         rt_val_ff <= regs_mem[rt_addr];
      end
   end

endmodule
